FILE: hdl/lnc_pkg.sv
// Shared types, codes and constants of the LFSR noise channel.
package lnc_pkg;

   // Field and register widths.
   localparam int unsigned LFSR_W     = 15;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned LENGTH_W   = 8;
   localparam int unsigned LEVEL_W    = 4;
   localparam int unsigned INDEX_W    = 5;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Feedback enters at the top bit of the shift register.
   localparam int unsigned FEEDBACK_BIT = 14;
   localparam int unsigned LONG_TAP     = 1;
   localparam int unsigned SHORT_TAP    = 6;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'hF;
   localparam logic [LFSR_W-1:0]  LFSR_SEED = 15'd1;

   // Item kinds carried on req_tuser.
   typedef enum logic [1:0] {
      CMD_SAMPLE_TICK    = 2'd0,
      CMD_ENVELOPE_CLOCK = 2'd1,
      CMD_LENGTH_CLOCK   = 2'd2,
      CMD_LENGTH_LOAD    = 2'd3
   } cmd_type;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_MODE         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CONSTANT_VOLUME_ON = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOOP_HALT          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ENVELOPE_PERIOD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CONSTANT_VOLUME    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLES_PER_SHIFT  = 3'd5;

   // Configuration as seen by the channel core.
   typedef struct packed {
      logic                  short_mode;
      logic                  constant_volume_on;
      logic                  loop_halt;
      logic [LEVEL_W-1:0]    envelope_period;
      logic [LEVEL_W-1:0]    constant_volume;
      logic [COUNT_W-1:0]    samples_per_shift;
   } cfg_type;

   // Length counter load values.
   localparam logic [LENGTH_W-1:0] LENGTH_TABLE [0:31] = '{
      8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
      8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
      8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
      8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
   };

endpackage

FILE: hdl/lnc_core.sv
// Channel state: LFSR, sample counter, length counter and envelope.
module lnc_core import lnc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 step_en,
   input  cmd_type              step_cmd,
   input  logic [INDEX_W-1:0]   step_index,
   output logic [LEVEL_W-1:0]   step_level
);

   logic [LFSR_W-1:0]   shift_ff, shift_in;
   logic [COUNT_W-1:0]  counter_ff, counter_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [LEVEL_W-1:0]  env_level_ff, env_level_in;
   logic [LEVEL_W-1:0]  env_div_ff, env_div_in;
   logic                restart_ff, restart_in;

   logic [COUNT_W-1:0]  counter_inc;
   logic                feedback;
   logic [LFSR_W-1:0]   shifted;
   logic [LFSR_W-1:0]   lfsr_after;

   // Next shift register value when a shift is due.
   always_comb begin
      feedback    = shift_ff[0] ^ (cfg.short_mode ? shift_ff[SHORT_TAP] : shift_ff[LONG_TAP]);
      shifted     = {feedback, shift_ff[LFSR_W-1:1]};
      counter_inc = counter_ff + 1'b1;
   end

   // State update for the item in the input stage.
   always_comb begin
      shift_in     = shift_ff;
      counter_in   = counter_ff;
      length_in    = length_ff;
      env_level_in = env_level_ff;
      env_div_in   = env_div_ff;
      restart_in   = restart_ff;
      lfsr_after   = shift_ff;
      step_level   = '0;
      if (step_en) begin
         case (step_cmd)
            CMD_SAMPLE_TICK: begin
               // A silent channel neither counts nor shifts.
               if (length_ff != '0) begin
                  if (counter_inc >= cfg.samples_per_shift) begin
                     counter_in = '0;
                     lfsr_after = shifted;
                  end else begin
                     counter_in = counter_inc;
                  end
                  shift_in = lfsr_after;
                  if (!lfsr_after[0]) begin
                     step_level = cfg.constant_volume_on ? cfg.constant_volume
                                                         : env_level_ff;
                  end
               end
            end
            CMD_ENVELOPE_CLOCK: begin
               if (restart_ff) begin
                  env_div_in   = cfg.envelope_period;
                  env_level_in = LEVEL_MAX;
                  restart_in   = 1'b0;
               end else if (env_div_ff != '0) begin
                  env_div_in = env_div_ff - 1'b1;
               end else begin
                  env_div_in = cfg.envelope_period;
                  if (env_level_ff != '0) begin
                     env_level_in = env_level_ff - 1'b1;
                  end else if (cfg.loop_halt) begin
                     env_level_in = LEVEL_MAX;
                  end
               end
            end
            CMD_LENGTH_CLOCK: begin
               if (!cfg.loop_halt && length_ff != '0) begin
                  length_in = length_ff - 1'b1;
               end
            end
            CMD_LENGTH_LOAD: begin
               length_in  = LENGTH_TABLE[step_index];
               restart_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= LFSR_SEED;
         counter_ff   <= '0;
         length_ff    <= '0;
         env_level_ff <= '0;
         env_div_ff   <= '0;
         restart_ff   <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         counter_ff   <= counter_in;
         length_ff    <= length_in;
         env_level_ff <= env_level_in;
         env_div_ff   <= env_div_in;
         restart_ff   <= restart_in;
      end
   end

   // The LFSR never falls into the all-zero lock-up state.
   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      shift_ff != '0)
      else $error("LFSR reached all zeros");

   // A length load always arms a restart and leaves a nonzero count.
   a_load_arms: assert property (@(posedge clock) disable iff (reset)
      step_en && step_cmd == CMD_LENGTH_LOAD |=> restart_ff && length_ff != '0)
      else $error("length load did not arm the channel");

endmodule

FILE: hdl/lfsr_noise_channel.sv
// Top level of the LFSR noise channel: configuration, input stage and result register.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/req_tready  tuser: command, tdata: length_index
//   rsp_      out        rsp_tvalid/rsp_tready  tdata: sample_level
//   csr_      in         csr_we                 csr_index, csr_wdata
//
// An item is taken into the input register, and when it leaves that register it updates the
// channel state and, for a sample tick, loads the result register.
// One item per cycle is sustained while the result register is not stalled.
// Only a sample tick waiting for a full, stalled result register holds the input.
// Reset is synchronous and returns the configuration, the channel state and the valid flags to their initial values.
module lfsr_noise_channel import lnc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_tuser,   // [1:0] command
   input  logic [7:0]             req_tdata,   // [4:0] length_index, [7:5] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [3:0] sample_level, [7:4] zero
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type              cfg_ff;
   logic                 in_valid_ff;
   cmd_type              in_cmd_ff;
   logic [INDEX_W-1:0]   in_index_ff;
   logic                 out_valid_ff;
   logic [LEVEL_W-1:0]   out_level_ff;

   logic                 in_is_tick;
   logic                 out_free;
   logic                 in_advance;
   logic                 req_accept;
   logic [LEVEL_W-1:0]   step_level;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SHORT_MODE:         cfg_ff.short_mode         <= csr_wdata[0];
            REG_CONSTANT_VOLUME_ON: cfg_ff.constant_volume_on <= csr_wdata[0];
            REG_LOOP_HALT:          cfg_ff.loop_halt          <= csr_wdata[0];
            REG_ENVELOPE_PERIOD:    cfg_ff.envelope_period    <= csr_wdata[LEVEL_W-1:0];
            REG_CONSTANT_VOLUME:    cfg_ff.constant_volume    <= csr_wdata[LEVEL_W-1:0];
            REG_SAMPLES_PER_SHIFT:  cfg_ff.samples_per_shift  <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Flow control: an item leaves the input stage unless it needs a stalled output.
   always_comb begin
      in_is_tick = (in_cmd_ff == CMD_SAMPLE_TICK);
      out_free   = !out_valid_ff || rsp_tready;
      in_advance = in_valid_ff && (!in_is_tick || out_free);
      req_tready = !in_valid_ff || in_advance;
      req_accept = req_tvalid && req_tready;
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff   <= cmd_type'(req_tuser);
         in_index_ff <= req_tdata[INDEX_W-1:0];
      end
   end

   lnc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .step_en    (in_advance),
      .step_cmd   (in_cmd_ff),
      .step_index (in_index_ff),
      .step_level (step_level)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_advance && in_is_tick) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance && in_is_tick) begin
         out_level_ff <= step_level;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(8-LEVEL_W){1'b0}}, out_level_ff};

   // A sample tick never overwrites a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff && $stable(out_level_ff))
      else $error("pending result was overwritten");

   // A new result only follows a sample tick leaving the input stage.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff && in_cmd_ff == CMD_SAMPLE_TICK))
      else $error("result without a sample tick");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the LFSR noise channel, checked against a local predictor.
module tb;
   import lnc_pkg::*;

   // Indexes that are not mapped to any register; writes to them must be ignored.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam int unsigned IDLE_LIMIT      = 1000;
   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned RANDOM_PHASES   = 12;
   localparam int unsigned ITEMS_PER_PHASE = 160;
   localparam int unsigned MAX_PRINTED     = 50;

   typedef struct {
      cmd_type            cmd;
      logic [INDEX_W-1:0] length_index;
   } noise_item_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser  = CMD_SAMPLE_TICK;   // [1:0] command
   logic [7:0]            req_tdata  = '0;                // [4:0] length_index, [7:5] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;                      // [3:0] sample_level, [7:4] zero
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Channel state and configuration as the predictor sees them.
   cfg_type             chan_cfg      = '0;
   logic [LFSR_W-1:0]   lfsr_state    = LFSR_SEED;
   logic [COUNT_W-1:0]  tick_count    = '0;
   logic [LENGTH_W-1:0] length_left   = '0;
   logic [LEVEL_W-1:0]  env_level     = '0;
   logic [LEVEL_W-1:0]  env_divider   = '0;
   logic                restart_armed = 1'b0;

   noise_item_type     pending_cmds[$];
   logic [LEVEL_W-1:0] expected_levels[$];
   noise_item_type     driven_item;
   logic [LEVEL_W-1:0] oldest_level;
   int unsigned        burst_left  = 0;
   int unsigned        gap_left    = 0;
   logic [15:0]        stall_pattern = '1;
   logic [3:0]         stall_step  = '0;
   int unsigned        idle_cycles = 0;
   int unsigned        error_count = 0;

   lfsr_noise_channel u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTED) begin
         $display("tb: mismatch at %0t: %s", $realtime, what);
      end
      error_count++;
   endtask

   // Mirror of a register write; unmapped indexes leave the configuration alone.
   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] value);
      case (index)
         REG_SHORT_MODE:         chan_cfg.short_mode         = value[0];
         REG_CONSTANT_VOLUME_ON: chan_cfg.constant_volume_on = value[0];
         REG_LOOP_HALT:          chan_cfg.loop_halt          = value[0];
         REG_ENVELOPE_PERIOD:    chan_cfg.envelope_period    = value[LEVEL_W-1:0];
         REG_CONSTANT_VOLUME:    chan_cfg.constant_volume    = value[LEVEL_W-1:0];
         REG_SAMPLES_PER_SHIFT:  chan_cfg.samples_per_shift  = value;
         default: ;
      endcase
   endfunction

   // Applies one accepted item to the channel state and, for a sample tick, queues the level it should produce.
   function automatic void advance_channel(input noise_item_type item);
      logic               feedback;
      logic [LEVEL_W-1:0] level;
      level = '0;
      case (item.cmd)
         CMD_SAMPLE_TICK: begin
            // A silent channel changes nothing and outputs zero.
            if (length_left != 0) begin
               tick_count = tick_count + 1'b1;
               if (tick_count >= chan_cfg.samples_per_shift) begin
                  tick_count = '0;
                  feedback = lfsr_state[0] ^ (chan_cfg.short_mode ? lfsr_state[SHORT_TAP]
                                                                  : lfsr_state[LONG_TAP]);
                  lfsr_state = {feedback, lfsr_state[LFSR_W-1:1]};
               end
               if (!lfsr_state[0]) begin
                  level = chan_cfg.constant_volume_on ? chan_cfg.constant_volume : env_level;
               end
            end
            expected_levels.push_back(level);
         end
         CMD_ENVELOPE_CLOCK: begin
            if (restart_armed) begin
               env_divider   = chan_cfg.envelope_period;
               env_level     = LEVEL_MAX;
               restart_armed = 1'b0;
            end else if (env_divider != 0) begin
               env_divider = env_divider - 1'b1;
            end else begin
               env_divider = chan_cfg.envelope_period;
               // At the floor the envelope wraps to full only when looping.
               if (env_level != 0) begin
                  env_level = env_level - 1'b1;
               end else if (chan_cfg.loop_halt) begin
                  env_level = LEVEL_MAX;
               end
            end
         end
         CMD_LENGTH_CLOCK: begin
            if (!chan_cfg.loop_halt && length_left != 0) begin
               length_left = length_left - 1'b1;
            end
         end
         default: begin
            length_left   = LENGTH_TABLE[item.length_index];
            restart_armed = 1'b1;
         end
      endcase
   endfunction

   function automatic void queue_item(input cmd_type cmd, input logic [INDEX_W-1:0] index);
      noise_item_type item;
      item.cmd          = cmd;
      item.length_index = index;
      pending_cmds.push_back(item);
   endfunction

   // Mostly sample ticks and envelope clocks, with enough length traffic
   // to start and stop the channel.
   function automatic noise_item_type random_item();
      noise_item_type item;
      int unsigned    pick;
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         item.cmd = CMD_SAMPLE_TICK;
      end else if (pick < 80) begin
         item.cmd = CMD_ENVELOPE_CLOCK;
      end else if (pick < 93) begin
         item.cmd = CMD_LENGTH_CLOCK;
      end else begin
         item.cmd = CMD_LENGTH_LOAD;
      end
      item.length_index = $urandom_range(0, 31);
      return item;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      apply_reg(index, value);
      @(posedge clock);
   endtask

   // Waits until every item has gone in and every level has come out,
   // then lets the pipeline settle.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || expected_levels.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_channel(driven_item);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               driven_item = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= driven_item.cmd;
               req_tdata  <= 8'(driven_item.length_index);
               if (burst_left > 1) begin
                  burst_left = burst_left - 1;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: a fresh 16-bit ready pattern each round, never all stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_step = '0;
      end else begin
         if (stall_step == 0) begin
            case ($urandom_range(0, 2))
               0:       stall_pattern = '1;
               1:       stall_pattern = 16'($urandom) | 16'h0001;
               default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
            endcase
         end
         rsp_tready <= stall_pattern[stall_step];
         stall_step = stall_step + 1'b1;
      end
   end

   // Result check against the oldest expected level.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_levels.size() == 0) begin
            report_mismatch($sformatf("result level %0d with none expected", rsp_tdata[3:0]));
         end else begin
            oldest_level = expected_levels.pop_front();
            if (rsp_tdata[3:0] !== oldest_level) begin
               report_mismatch($sformatf("sample_level %0d, expected %0d",
                                         rsp_tdata[3:0], oldest_level));
            end
            if (rsp_tdata[7:4] !== 4'h0) begin
               report_mismatch($sformatf("padding bits %h not zero", rsp_tdata[7:4]));
            end
         end
      end
   end

   // Watchdog on cycles in which nothing moves.
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed items at reset settings, then random phases with fresh settings each.
   initial begin
      int unsigned phase;
      int unsigned n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_reg(REG_SPARE_LO, 16'($urandom));
      write_reg(REG_SPARE_HI, 16'($urandom));
      csr_we <= 1'b0;

      // Silent channel, length clock at zero, envelope floor without looping.
      queue_item(CMD_SAMPLE_TICK, 5'd31);
      queue_item(CMD_LENGTH_CLOCK, 5'd0);
      queue_item(CMD_ENVELOPE_CLOCK, 5'd21);
      // Both ends of the length table; zero period shifts on every tick.
      queue_item(CMD_LENGTH_LOAD, 5'd31);
      queue_item(CMD_LENGTH_LOAD, 5'd0);
      repeat (4) queue_item(CMD_SAMPLE_TICK, 5'd10);
      // Envelope restart, then decay steps.
      queue_item(CMD_ENVELOPE_CLOCK, 5'd0);
      repeat (3) queue_item(CMD_SAMPLE_TICK, 5'd31);
      repeat (2) queue_item(CMD_ENVELOPE_CLOCK, 5'd31);
      repeat (2) queue_item(CMD_SAMPLE_TICK, 5'd0);
      // Short length run down to zero and past it.
      queue_item(CMD_LENGTH_LOAD, 5'd3);
      repeat (3) queue_item(CMD_LENGTH_CLOCK, 5'd17);
      queue_item(CMD_SAMPLE_TICK, 5'd0);
      queue_item(CMD_LENGTH_LOAD, 5'd1);
      repeat (2) queue_item(CMD_SAMPLE_TICK, 5'd14);
      wait_until_drained();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               write_reg(REG_SHORT_MODE, 16'd1);
               write_reg(REG_CONSTANT_VOLUME_ON, 16'd1);
               write_reg(REG_LOOP_HALT, 16'd1);
               write_reg(REG_ENVELOPE_PERIOD, 16'd15);
               write_reg(REG_CONSTANT_VOLUME, 16'd15);
               write_reg(REG_SAMPLES_PER_SHIFT, 16'hFFFF);
            end
            1: begin
               // Period drops below the running count here.
               write_reg(REG_SHORT_MODE, 16'd0);
               write_reg(REG_CONSTANT_VOLUME_ON, 16'd0);
               write_reg(REG_LOOP_HALT, 16'd0);
               write_reg(REG_ENVELOPE_PERIOD, 16'd0);
               write_reg(REG_CONSTANT_VOLUME, 16'd0);
               write_reg(REG_SAMPLES_PER_SHIFT, 16'd0);
            end
            default: begin
               write_reg(REG_SHORT_MODE, 16'($urandom_range(0, 1)));
               write_reg(REG_CONSTANT_VOLUME_ON, 16'($urandom_range(0, 1)));
               write_reg(REG_LOOP_HALT, 16'($urandom_range(0, 1)));
               write_reg(REG_ENVELOPE_PERIOD, 16'($urandom_range(0, 15)));
               write_reg(REG_CONSTANT_VOLUME, 16'($urandom_range(0, 15)));
               write_reg(REG_SAMPLES_PER_SHIFT, ($urandom_range(0, 7) == 0)
                                                ? 16'($urandom_range(0, 200))
                                                : 16'($urandom_range(0, 6)));
               if ($urandom_range(0, 3) == 0) begin
                  write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                            16'($urandom));
               end
            end
         endcase
         csr_we <= 1'b0;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            pending_cmds.push_back(random_item());
         end
         wait_until_drained();
      end

      if (expected_levels.size() != 0) begin
         report_mismatch($sformatf("%0d expected levels never arrived", expected_levels.size()));
      end
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
